FILE: rtl/core/fsv_pkg.sv
// shared types, constants and helper functions for the three-axis smoother
// and velocity estimator
// depends on nothing; imported by every module of the block
package fsv_pkg;

  localparam int NUM_AXES     = 3;
  localparam int DATA_W       = 32;
  localparam int COEF_W       = 16;
  localparam int RATE_W       = 10;
  localparam int NCOEF        = 5;
  localparam int WEIGHT_W     = 32;
  localparam int WEIGHT_FRAC  = 24;
  localparam int ACC_W        = 64;
  localparam int SCALED_W     = ACC_W - 12 + RATE_W + 1;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int DEF_TAPS     = 5;
  localparam int DEF_HISTORY  = 10;
  localparam int MAX_HISTORY  = 32;

  localparam logic signed [COEF_W-1:0] COEF_RESET = 16'sd3277;
  localparam logic [RATE_W-1:0]        RATE_RESET = 10'd50;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_COEF_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIR,
    ST_FIR_END,
    ST_WB,
    ST_VEL,
    ST_VEL_END,
    ST_SCALE,
    ST_DONE
  } fsv_state_t;

  // per-cycle commands from the sequencer to the axis lanes
  typedef struct packed {
    logic raw_shift;
    logic use_hist;
    logic mul_en;
    logic acc_clr;
    logic hist_wr;
    logic scale_en;
  } fsv_ctl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return hi[DATA_W-1:0];
    end else if (v < lo) begin
      return lo[DATA_W-1:0];
    end
    return v[DATA_W-1:0];
  endfunction

  // endpoint derivative weight of a natural cubic spline through hist unit-spaced
  // nodes, exact rational solution rounded half away from zero to Q.24
  function automatic logic signed [WEIGHT_W-1:0] spline_weight(input int hist, input int idx);
    longint                  p [MAX_HISTORY+2];
    longint                  d;
    longint                  num;
    logic [63:0]             mag;
    logic [63:0]             du;
    logic [63:0]             q;
    logic [63:0]             r;
    logic signed [63:0]      qs;
    int                      k;
    logic                    neg;
    for (int j = 0; j < MAX_HISTORY + 2; j++) p[j] = 0;
    k    = hist - 2;
    p[1] = 1;
    for (int j = 1; j < k; j++) p[j+1] = -4 * p[j] - p[j-1];
    d = p[k-1] + 4 * p[k];
    if (d < 0) begin
      d = -d;
      for (int j = 0; j <= k; j++) p[j] = -p[j];
    end
    num = -2 * p[idx];
    if (idx >= 1) num = num + p[idx-1];
    if (idx + 1 <= k) num = num + p[idx+1];
    if (idx > k) num = (idx - 1 <= k) ? p[idx-1] : 0;
    if (idx == hist - 1) num = num + d;
    if (idx == hist - 2) num = num - d;
    neg = (num < 0);
    mag = neg ? 64'(-num) : 64'(num);
    du  = 64'(d);
    q   = '0;
    r   = '0;
    // restoring long division, integer bits then fraction bits
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], mag[b]};
      q = {q[62:0], 1'b0};
      if (r >= du) begin
        r    = r - du;
        q[0] = 1'b1;
      end
    end
    for (int b = 0; b < WEIGHT_FRAC; b++) begin
      r = {r[62:0], 1'b0};
      q = {q[62:0], 1'b0};
      if (r >= du) begin
        r    = r - du;
        q[0] = 1'b1;
      end
    end
    if ({r[62:0], 1'b0} >= du) q = q + 64'd1;
    qs = neg ? -$signed(q) : $signed(q);
    return qs[WEIGHT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/fsv_lane.sv
// one axis lane: raw window, filtered history, shared multiply-accumulate,
// rate scaling and rounding; depends on fsv_pkg
module fsv_lane #(
  parameter int TAPS    = fsv_pkg::DEF_TAPS,
  parameter int HISTORY = fsv_pkg::DEF_HISTORY,
  parameter int CNT_W   = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fsv_pkg::fsv_ctl_t                   ctl,
  input  logic [CNT_W-1:0]                    idx,
  input  logic signed [fsv_pkg::DATA_W-1:0]   op_a,
  input  logic signed [fsv_pkg::DATA_W-1:0]   sample,
  input  logic [fsv_pkg::RATE_W-1:0]          rate,
  output logic signed [fsv_pkg::DATA_W-1:0]   smooth,
  output logic signed [fsv_pkg::DATA_W-1:0]   vel
);
  import fsv_pkg::*;

  localparam int RAW_IW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int HIST_IW = $clog2(HISTORY);

  logic signed [DATA_W-1:0]   raw_r  [TAPS];
  logic signed [DATA_W-1:0]   hist_r [HISTORY];
  logic signed [ACC_W-1:0]    prod_r;
  logic                       prod_vld_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [SCALED_W-1:0] scaled_r;
  logic signed [DATA_W-1:0]   smooth_r;

  logic signed [DATA_W-1:0]   op_b;
  logic signed [ACC_W-1:0]    fir_rnd;
  logic signed [ACC_W-1:0]    vel_rnd;
  logic signed [DATA_W-1:0]   filt;

  assign op_b    = ctl.use_hist ? hist_r[idx[HIST_IW-1:0]] : raw_r[idx[RAW_IW-1:0]];
  // round half up then drop the coefficient fraction
  assign fir_rnd = (acc_r + 64'sd8192) >>> 14;
  assign filt    = sat32(fir_rnd);
  assign vel_rnd = (ACC_W'(scaled_r) + 64'sd2048) >>> 12;
  assign vel     = sat32(vel_rnd);
  assign smooth  = smooth_r;

  always_ff @(posedge clk) begin
    if (ctl.raw_shift) begin
      for (int i = 0; i < TAPS - 1; i++) raw_r[i] <= raw_r[i+1];
      raw_r[TAPS-1] <= sample;
    end
    if (ctl.hist_wr) begin
      for (int i = 0; i < HISTORY - 1; i++) hist_r[i] <= hist_r[i+1];
      hist_r[HISTORY-1] <= filt;
      smooth_r          <= filt;
    end
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctl.scale_en) begin
      scaled_r <= $signed(acc_r[ACC_W-1:12]) * $signed({1'b0, rate});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= ctl.mul_en;
      if (ctl.acc_clr) begin
        acc_r <= '0;
      end else if (prod_vld_r) begin
        acc_r <= acc_r + prod_r;
      end
    end
  end

endmodule

FILE: rtl/core/fsv_ctrl.sv
// sequencer: fill count, tap and history index, command struct for the lanes
// depends on fsv_pkg
module fsv_ctrl #(
  parameter int TAPS    = fsv_pkg::DEF_TAPS,
  parameter int HISTORY = fsv_pkg::DEF_HISTORY,
  parameter int CNT_W   = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               slot_free,
  output logic               in_ready,
  output logic               load,
  output fsv_pkg::fsv_ctl_t  ctl,
  output logic [CNT_W-1:0]   idx
);
  import fsv_pkg::*;

  localparam int FULL_COUNT = TAPS + HISTORY - 1;
  localparam int FILL_W     = $clog2(TAPS + HISTORY);

  fsv_state_t        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              emit_r, emit_nxt;

  assign idx = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      idx_r   <= '0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    emit_nxt  = emit_r;
    in_ready  = 1'b0;
    load      = 1'b0;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.raw_shift = 1'b1;
          ctl.acc_clr   = 1'b1;
          idx_nxt       = '0;
          if (fill_r < FILL_W'(FULL_COUNT)) begin
            fill_nxt = fill_r + 1'b1;
            emit_nxt = 1'b0;
            if (fill_r >= FILL_W'(TAPS - 1)) state_nxt = ST_FIR;
          end else begin
            emit_nxt  = 1'b1;
            state_nxt = ST_FIR;
          end
        end
      end
      ST_FIR: begin
        ctl.mul_en = 1'b1;
        if (idx_r == CNT_W'(TAPS - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_FIR_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIR_END: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        ctl.hist_wr = 1'b1;
        ctl.acc_clr = 1'b1;
        state_nxt   = emit_r ? ST_VEL : ST_IDLE;
      end
      ST_VEL: begin
        ctl.use_hist = 1'b1;
        ctl.mul_en   = 1'b1;
        if (idx_r == CNT_W'(HISTORY - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_VEL_END;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_VEL_END: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        ctl.scale_en = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/core/fsv_merge.sv
// merging stage: gathers the three lane results into one output item and
// holds it until taken; depends on fsv_pkg
module fsv_merge (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic                                                   load,
  input  logic [fsv_pkg::NUM_AXES-1:0][fsv_pkg::DATA_W-1:0]      lane_vel,
  input  logic [fsv_pkg::NUM_AXES-1:0][fsv_pkg::DATA_W-1:0]      lane_smooth,
  input  logic                                                   out_tready,
  output logic                                                   out_tvalid,
  output logic [2*fsv_pkg::NUM_AXES*fsv_pkg::DATA_W-1:0]         out_tdata,
  output logic                                                   slot_free
);
  import fsv_pkg::*;

  logic                                 tvalid_r;
  logic [2*NUM_AXES*DATA_W-1:0]         tdata_r;

  assign slot_free  = !tvalid_r || out_tready;
  assign out_tvalid = tvalid_r;
  assign out_tdata  = tdata_r;

  always_ff @(posedge clk) begin
    if (load) begin
      tdata_r <= {lane_smooth, lane_vel};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else if (load) begin
      tvalid_r <= 1'b1;
    end else if (out_tready) begin
      tvalid_r <= 1'b0;
    end
  end

endmodule

FILE: rtl/core/fir_smoothed_spline_velocity_3axis_core.sv
// top level: x,y,z position smoother (fir) and natural-spline velocity estimator
// an emitting item runs the fir pass, history write, velocity pass and rate scaling,
// then waits for the output register to be free; no new item is taken before it is
// through, set by the serial multiply-accumulate of each lane over the taps and then
// the history; warm-up items give no result: TAPS-1 shift in, then the history fills
// reset: rst_n synchronous active low, clears control and fill count, config to defaults
module fir_smoothed_spline_velocity_3axis_core #(
  parameter int TAPS    = fsv_pkg::DEF_TAPS,
  parameter int HISTORY = fsv_pkg::DEF_HISTORY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [3*fsv_pkg::DATA_W-1:0]       in_tdata,   // pos_x, pos_y, pos_z
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [6*fsv_pkg::DATA_W-1:0]       out_tdata,  // vel_x, vel_y, vel_z,
                                                         // smooth_x, smooth_y, smooth_z
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [fsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fsv_pkg::*;

  // shared index counter spans the longer of the two passes
  localparam int MAX_LEN = (TAPS > HISTORY) ? TAPS : HISTORY;
  localparam int CNT_W   = $clog2(MAX_LEN);
  localparam int RAW_IW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int HIST_IW = $clog2(HISTORY);

  // configuration registers
  logic signed [COEF_W-1:0] coef_r [NCOEF];
  logic [RATE_W-1:0]        rate_r;

  // spline weight rom, fixed at elaboration from HISTORY
  logic signed [WEIGHT_W-1:0] wrom [HISTORY];

  fsv_ctl_t                               ctl;
  logic [CNT_W-1:0]                       idx;
  logic                                   load;
  logic                                   slot_free;
  logic signed [DATA_W-1:0]               op_a;
  logic [NUM_AXES-1:0][DATA_W-1:0]        lane_vel;
  logic [NUM_AXES-1:0][DATA_W-1:0]        lane_smooth;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) coef_r[i] <= COEF_RESET;
      rate_r <= RATE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index) inside
        [REG_COEF_0:REG_COEF_4]: coef_r[cfg_index] <= $signed(cfg_wdata[COEF_W-1:0]);
        REG_RATE:                rate_r            <= cfg_wdata[RATE_W-1:0];
        default:                 ;  // writes beyond the map are dropped
      endcase
    end
  end

  for (genvar g = 0; g < HISTORY; g++) begin : g_wrom
    localparam logic signed [WEIGHT_W-1:0] WT = spline_weight(HISTORY, g);
    assign wrom[g] = WT;
  end

  // common multiplier operand: fir tap during filtering, spline weight during the
  // velocity pass; the lanes supply their own sample or history entry
  assign op_a = ctl.use_hist ? wrom[idx[HIST_IW-1:0]]
                             : DATA_W'(coef_r[idx[RAW_IW-1:0]]);

  fsv_ctrl #(
    .TAPS    (TAPS),
    .HISTORY (HISTORY),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .slot_free (slot_free),
    .in_ready  (in_tready),
    .load      (load),
    .ctl       (ctl),
    .idx       (idx)
  );

  // one lane per axis, all stepping together
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    logic signed [DATA_W-1:0] vel_a;
    logic signed [DATA_W-1:0] smooth_a;

    fsv_lane #(
      .TAPS    (TAPS),
      .HISTORY (HISTORY),
      .CNT_W   (CNT_W)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .idx    (idx),
      .op_a   (op_a),
      .sample ($signed(in_tdata[a*DATA_W +: DATA_W])),
      .rate   (rate_r),
      .smooth (smooth_a),
      .vel    (vel_a)
    );

    assign lane_vel[a]    = vel_a;
    assign lane_smooth[a] = smooth_a;
  end

  // output register parts the result side from the lanes
  fsv_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .lane_vel    (lane_vel),
    .lane_smooth (lane_smooth),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .slot_free   (slot_free)
  );

endmodule

FILE: sim/velocity_checker.sv
// checker for the three-axis fir smoother and spline velocity estimator
// watches the item, result and register-write ports, predicts each result and compares
// depends on fsv_pkg for widths, register indexes and reset values
module velocity_checker #(
  parameter int TAPS    = fsv_pkg::DEF_TAPS,
  parameter int HISTORY = fsv_pkg::DEF_HISTORY
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  input  logic                               in_tready,
  input  logic [3*fsv_pkg::DATA_W-1:0]       in_tdata,   // pos_x, pos_y, pos_z
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [6*fsv_pkg::DATA_W-1:0]       out_tdata,  // vel_x, vel_y, vel_z,
                                                         // smooth_x, smooth_y, smooth_z
  input  logic                               cfg_wr_en,
  input  logic [fsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                 fail_count,
  output int                                 pending_count,
  output int                                 result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsv_pkg::*;

  localparam int REPORT_LIMIT = 10;
  localparam int FULL_FILL    = TAPS + HISTORY - 1;

  typedef logic signed [DATA_W-1:0] q16_t;

  // first member sits in the top bits, so vel_x ends up lowest as on the port
  typedef struct packed {
    q16_t smooth_z;
    q16_t smooth_y;
    q16_t smooth_x;
    q16_t vel_z;
    q16_t vel_y;
    q16_t vel_x;
  } motion_t;

  q16_t                     raw_win [TAPS][NUM_AXES];
  q16_t                     hist    [HISTORY][NUM_AXES];
  int unsigned              fill;
  logic signed [COEF_W-1:0] coef_reg [NCOEF];
  logic [RATE_W-1:0]        rate_reg;
  longint                   spline_w [HISTORY];

  motion_t                  pending_results [$];
  motion_t                  want;
  motion_t                  got;
  motion_t                  fresh;
  int                       failures;
  int                       results_checked;

  function automatic q16_t clamp_q16(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (v < -longint'(32'sh7FFF_FFFF) - 1) return 32'sh8000_0000;
    return v[DATA_W-1:0];
  endfunction

  // endpoint derivative weights of the natural spline, rounded to q.24
  function automatic void build_spline_table();
    longint p [HISTORY+2];
    longint d;
    longint num;
    longint mag;
    longint q;
    longint r;
    int     k;
    for (int j = 0; j < HISTORY + 2; j++) p[j] = 0;
    k    = HISTORY - 2;
    p[1] = 1;
    for (int j = 1; j < k; j++) p[j+1] = -4 * p[j] - p[j-1];
    d = p[k-1] + 4 * p[k];
    if (d < 0) begin
      d = -d;
      for (int j = 0; j <= k; j++) p[j] = -p[j];
    end
    for (int i = 0; i < HISTORY; i++) begin
      if (i > k) begin
        num = (i - 1 <= k) ? p[i-1] : 0;
      end else begin
        num = -2 * p[i];
        if (i >= 1) num = num + p[i-1];
        if (i + 1 <= k) num = num + p[i+1];
      end
      if (i == HISTORY - 1) num = num + d;
      if (i == HISTORY - 2) num = num - d;
      mag = (num < 0) ? -num : num;
      q   = mag / d;
      r   = mag % d;
      // fraction bits one at a time so a long history cannot overflow
      for (int b = 0; b < WEIGHT_FRAC; b++) begin
        r = r <<< 1;
        q = q <<< 1;
        if (r >= d) begin
          r = r - d;
          q = q + 1;
        end
      end
      if (2 * r >= d) q = q + 1;
      spline_w[i] = (num < 0) ? -q : q;
    end
  endfunction

  // one position sample in; returns 1 when it yields a velocity result
  function automatic bit advance_estimator(input logic [3*DATA_W-1:0] pos_bits,
                                           output motion_t res);
    q16_t   filt [NUM_AXES];
    q16_t   vel  [NUM_AXES];
    longint acc;
    bit     emit;
    res = '0;
    for (int i = 0; i + 1 < TAPS; i++)
      for (int a = 0; a < NUM_AXES; a++) raw_win[i][a] = raw_win[i+1][a];
    for (int a = 0; a < NUM_AXES; a++) raw_win[TAPS-1][a] = pos_bits[a*DATA_W +: DATA_W];

    if (fill < FULL_FILL) begin
      fill = fill + 1;
      if (fill < TAPS) return 1'b0;
      emit = 1'b0;
    end else begin
      emit = 1'b1;
    end

    for (int a = 0; a < NUM_AXES; a++) begin
      acc = 0;
      for (int i = 0; i < TAPS; i++) acc = acc + longint'(coef_reg[i]) * longint'(raw_win[i][a]);
      filt[a] = clamp_q16((acc + (64'sd1 <<< 13)) >>> 14);
    end
    for (int i = 0; i + 1 < HISTORY; i++)
      for (int a = 0; a < NUM_AXES; a++) hist[i][a] = hist[i+1][a];
    for (int a = 0; a < NUM_AXES; a++) hist[HISTORY-1][a] = filt[a];

    if (!emit) return 1'b0;

    for (int a = 0; a < NUM_AXES; a++) begin
      acc = 0;
      for (int i = 0; i < HISTORY; i++) acc = acc + spline_w[i] * longint'(hist[i][a]);
      acc    = (acc >>> 12) * longint'(rate_reg);
      vel[a] = clamp_q16((acc + (64'sd1 <<< 11)) >>> 12);
    end
    res.vel_x    = vel[0];
    res.vel_y    = vel[1];
    res.vel_z    = vel[2];
    res.smooth_x = filt[0];
    res.smooth_y = filt[1];
    res.smooth_z = filt[2];
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input q16_t want_v, input q16_t got_v);
    if (want_v !== got_v) begin
      failures = failures + 1;
      if (failures <= REPORT_LIMIT)
        $display("result %0d: %s expected %0d (%h), got %0d (%h)",
                 results_checked, name, want_v, want_v, got_v, got_v);
    end
  endtask

  initial begin
    build_spline_table();
    failures        = 0;
    results_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCOEF; i++) coef_reg[i] = COEF_RESET;
      rate_reg = RATE_RESET;
      fill     = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int i = 0; i < TAPS; i++) raw_win[i][a] = '0;
        for (int i = 0; i < HISTORY; i++) hist[i][a] = '0;
      end
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index <= REG_COEF_4) begin
          coef_reg[cfg_index - REG_COEF_0] = cfg_wdata;
        end else if (cfg_index == REG_RATE) begin
          rate_reg = cfg_wdata[RATE_W-1:0];
        end
      end

      if (out_tvalid && out_tready) begin
        got = motion_t'(out_tdata);
        if (pending_results.size() == 0) begin
          failures = failures + 1;
          if (failures <= REPORT_LIMIT)
            $display("result with nothing outstanding: %h", out_tdata);
        end else begin
          want = pending_results.pop_front();
          check_field("vel_x", want.vel_x, got.vel_x);
          check_field("vel_y", want.vel_y, got.vel_y);
          check_field("vel_z", want.vel_z, got.vel_z);
          check_field("smooth_x", want.smooth_x, got.smooth_x);
          check_field("smooth_y", want.smooth_y, got.smooth_y);
          check_field("smooth_z", want.smooth_z, got.smooth_z);
          results_checked = results_checked + 1;
        end
      end

      if (in_tvalid && in_tready) begin
        if (advance_estimator(in_tdata, fresh))
          pending_results.insert(pending_results.size(), fresh);
      end
    end
    fail_count    <= failures;
    pending_count <= pending_results.size();
    result_count  <= results_checked;
  end

endmodule

FILE: sim/testbench.sv
// top of the regression for the three-axis fir smoother and velocity estimator
// drives items, register writes and output back-pressure; checking lives in velocity_checker
// depends on fsv_pkg, velocity_checker and fir_smoothed_spline_velocity_3axis_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fsv_pkg::*;

  localparam int TAPS_N          = DEF_TAPS;
  localparam int HIST_N          = DEF_HISTORY;
  localparam int CLK_HALF        = 10;
  localparam int RESET_CYCLES    = 11;
  // margin after the drain so that warm-up work that gives no result can finish
  localparam int SETTLE_CYCLES   = 2 * (TAPS_N + HIST_N + 6);
  localparam int DIRECTED_ITEMS  = 22;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 154;
  localparam int HOLD_AFTER      = 150;
  localparam int LONG_HOLD       = 400;
  localparam int TIMEOUT_NS      = 10_000_000;

  localparam logic signed [DATA_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] POS_MIN = 32'sh8000_0000;

  // indexes past the map, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_RATE + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_RATE + 3'd2;

  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic                      in_tready;
  logic [3*DATA_W-1:0]       in_tdata   = '0;   // pos_x, pos_y, pos_z
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [6*DATA_W-1:0]       out_tdata;         // vel_x, vel_y, vel_z, smooth_x, smooth_y, smooth_z
  logic                      cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata  = '0;

  int                        fail_count;
  int                        pending_count;
  int                        result_count;

  // sender bookkeeping
  int                        burst_left    = 0;
  int                        items_sent    = 0;
  int                        setting_count = 1;
  logic signed [DATA_W-1:0]  track_pos  [NUM_AXES];
  logic signed [DATA_W-1:0]  track_step [NUM_AXES];

  // receiver bookkeeping
  int                        rx_seen;
  int                        rx_mode;
  int                        rx_mode_left;
  int                        hold_left;
  logic                      hold_done;

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  fir_smoothed_spline_velocity_3axis_core #(
    .TAPS    (TAPS_N),
    .HISTORY (HIST_N)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  velocity_checker #(
    .TAPS    (TAPS_N),
    .HISTORY (HIST_N)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  // receiver: ready pattern switches between always-ready, half, sparse and mostly-ready
  // stretches; once, after some results, it holds off long enough to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready   <= 1'b0;
      rx_seen      <= 0;
      rx_mode      <= 0;
      rx_mode_left <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) rx_seen <= rx_seen + 1;
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (!hold_done && rx_seen == HOLD_AFTER) begin
        out_tready <= 1'b0;
        hold_left  <= LONG_HOLD;
        hold_done  <= 1'b1;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= $urandom_range(0, 3);
          rx_mode_left <= $urandom_range(16, 128);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 1) == 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // offer one item and wait for the handshake; bursts of random length with
  // random gaps in between, and now and then no gap at all
  task automatic send_pos(input logic signed [DATA_W-1:0] px,
                          input logic signed [DATA_W-1:0] py,
                          input logic signed [DATA_W-1:0] pz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pz, py, px};
    // ready comes from registered state only, so it is steady at the falling edge
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    burst_left = burst_left - 1;
    items_sent = items_sent + 1;
  endtask

  // write enable stays high across back-to-back writes; caller drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // stop offering, let every expected result drain, then give the block time to
  // finish any warm-up item that produces nothing
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register settings per phase: both extremes of the taps and rate first, then
  // a zero rate with a single tap, a rate word with junk above bit 9, then random
  task automatic apply_setting(input int ph);
    logic [CFG_DATA_W-1:0] coef_word;
    logic [CFG_DATA_W-1:0] rate_word;
    for (int i = 0; i < NCOEF; i++) begin
      case (ph)
        1:       coef_word = 16'h7FFF;
        2:       coef_word = 16'h8000;
        3:       coef_word = (i == 2) ? 16'h4000 : 16'h0000;
        4:       coef_word = (i == 0) ? 16'hC000 : ((i == NCOEF - 1) ? 16'h4000 : 16'h0000);
        default: coef_word = 16'($urandom);
      endcase
      write_reg(REG_COEF_0 + CFG_IDX_W'(i), coef_word);
    end
    case (ph)
      1:       rate_word = 16'd1000;
      2:       rate_word = 16'd1;
      3:       rate_word = 16'd0;
      4:       rate_word = 16'hFFFF;
      default: rate_word = {6'($urandom), 10'($urandom_range(1, 1000))};
    endcase
    write_reg(REG_RATE, rate_word);
    // stray writes beyond the map must leave the settings alone
    if (ph == 3 || ph > 4) begin
      write_reg(REG_SPARE_LO, 16'($urandom));
      write_reg(REG_SPARE_HI, 16'($urandom));
    end
    cfg_wr_en <= 1'b0;
    setting_count = setting_count + 1;
  endtask

  // mostly smooth motion per axis (drift plus a little jitter), some fully random
  // samples, and some samples at the rails, zero or all ones
  task automatic run_random(input int n);
    logic signed [DATA_W-1:0] p [NUM_AXES];
    int                       pick;
    for (int a = 0; a < NUM_AXES; a++) begin
      track_pos[a]  = $signed($urandom) >>> $urandom_range(4, 14);
      track_step[a] = $signed($urandom) >>> $urandom_range(12, 24);
    end
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      for (int a = 0; a < NUM_AXES; a++) begin
        if (pick < 80) begin
          if ($urandom_range(0, 15) == 0) track_step[a] = $signed($urandom) >>> $urandom_range(12, 24);
          track_pos[a] = track_pos[a] + track_step[a];
          p[a] = track_pos[a] + int'($urandom_range(0, 255)) - 128;
        end else if (pick < 92) begin
          p[a] = $urandom;
        end else begin
          case ($urandom_range(0, 3))
            0:       p[a] = POS_MAX;
            1:       p[a] = POS_MIN;
            2:       p[a] = '0;
            default: p[a] = '1;
          endcase
        end
      end
      send_pos(p[0], p[1], p[2]);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset settings: the first samples only fill the tap window,
    // the next ones fill the history, the rest produce results; rails and bit
    // patterns on every axis
    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      case (i % 4)
        0:       send_pos(POS_MAX, POS_MIN, '0);
        1:       send_pos(POS_MIN, POS_MAX, '1);
        2:       send_pos(DATA_W'(i) <<< 16, -(DATA_W'(i) <<< 16), 32'h5555_5555);
        default: send_pos(32'hAAAA_AAAA, 32'sd1, DATA_W'(i) <<< 20);
      endcase
    end
    settle_idle();

    for (int ph = 1; ph <= NUM_PHASES; ph++) begin
      apply_setting(ph);
      run_random(ITEMS_PER_PHASE);
      settle_idle();
    end

    $display("%0d position items over %0d register settings, %0d velocity results compared",
             items_sent, setting_count, result_count);
    $display("output held off once for %0d cycles while items kept coming", LONG_HOLD);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
